FILE: src/sacl_pkg.sv
`default_nettype none

package sacl_pkg;

	localparam int WAYS_DEF        = 4;
	localparam int SET_BITS_DEF    = 6;
	localparam int OFFSET_BITS_DEF = 4;

	localparam int ADDR_W     = 32;
	localparam int WORD_W     = 32;
	localparam int STAMP_W    = 32;
	localparam int CNT_W      = 32;
	localparam int WAY_OUT_W  = 2;
	localparam int VLA_W      = 28;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 1;

	typedef logic [ADDR_W-1:0]    addr_t;
	typedef logic [WORD_W-1:0]    word_t;
	typedef logic [STAMP_W-1:0]   stamp_t;
	typedef logic [CNT_W-1:0]     cnt_t;
	typedef logic [WAY_OUT_W-1:0] way_out_t;
	typedef logic [VLA_W-1:0]     vla_t;

	localparam logic [CFG_IDX_W-1:0] REG_WRITE_BACK_MODE     = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WRITE_ALLOCATE_MODE = 1'd1;

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

endpackage

`default_nettype wire

FILE: src/sacl_lru_tree.sv
`default_nettype none

module sacl_lru_tree #(
	parameter int WAYS  = sacl_pkg::WAYS_DEF,
	parameter int WAY_W = 2
) (
	input  logic [WAYS*sacl_pkg::STAMP_W-1:0] stamps,
	output logic [WAY_W-1:0]                  lru_way
);
	import sacl_pkg::*;

	localparam int LEAVES = 1 << $clog2(WAYS);

	logic [LEAVES*STAMP_W-1:0] padded;
	logic                      nd_present [2*LEAVES];
	stamp_t                    nd_stamp   [2*LEAVES];
	logic [WAY_W-1:0]          nd_idx     [2*LEAVES];

	assign padded = (LEAVES*STAMP_W)'(stamps);

	// heap-ordered min tree; on equal stamps the right (higher) way wins
	always_comb begin
		nd_present[0] = 1'b0;
		nd_stamp[0]   = '0;
		nd_idx[0]     = '0;
		for (int i = 0; i < LEAVES; i++) begin
			nd_present[LEAVES+i] = (i < WAYS);
			nd_stamp[LEAVES+i]   = padded[i*STAMP_W +: STAMP_W];
			nd_idx[LEAVES+i]     = WAY_W'(i);
		end
		for (int n = LEAVES - 1; n >= 1; n--) begin
			if (nd_present[2*n+1] &&
			    (!nd_present[2*n] || nd_stamp[2*n+1] <= nd_stamp[2*n])) begin
				nd_present[n] = 1'b1;
				nd_stamp[n]   = nd_stamp[2*n+1];
				nd_idx[n]     = nd_idx[2*n+1];
			end else begin
				nd_present[n] = nd_present[2*n];
				nd_stamp[n]   = nd_stamp[2*n];
				nd_idx[n]     = nd_idx[2*n];
			end
		end
	end

	assign lru_way = nd_idx[1];

endmodule

`default_nettype wire

FILE: src/set_assoc_cache_lru_controller.sv
// Tag and replacement controller for a WAYS-way set-associative cache with LRU
// replacement, selectable write-back/write-through and write-allocate/no-allocate.
// Each access produces one result telling the datapath whether it hit, which way
// is used, whether a dirty victim must be written back (and its line address),
// whether the line must be filled, and whether the word goes to memory. All per-set
// state (valid, dirty, tags, stamps) is one row of a single-port synchronous memory.
// An access first reads the row of its set, then does the tag compare, victim pick and
// row write-back; that last step waits only while a finished result is held by
// out_stall. After reset the block sweeps the memory, one set per cycle, clearing
// all 2^SET_BITS sets before it takes the first access; config writes are
// taken at any time but must be issued only while no access is in flight.
`default_nettype none

module set_assoc_cache_lru_controller #(
	parameter int WAYS        = sacl_pkg::WAYS_DEF,
	parameter int SET_BITS    = sacl_pkg::SET_BITS_DEF,
	parameter int OFFSET_BITS = sacl_pkg::OFFSET_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [sacl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [sacl_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           opcode,
	input  sacl_pkg::addr_t                address,
	input  sacl_pkg::word_t                store_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic                           hit,
	output sacl_pkg::way_out_t             way,
	output logic                           victim_writeback,
	output sacl_pkg::vla_t                 victim_line_address,
	output logic                           line_fill,
	output logic                           memory_write,
	output logic                           cached,
	output sacl_pkg::cnt_t                 hit_count
);
	import sacl_pkg::*;

	localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int SET_W = (SET_BITS > 0) ? SET_BITS : 1;
	localparam int NSETS = 1 << SET_BITS;
	localparam int TAG_W = ADDR_W - SET_BITS - OFFSET_BITS;
	localparam logic [ADDR_W-1:0] SET_MASK = ADDR_W'((1 << SET_BITS) - 1);

	// row layout: valid bits, dirty bits, tags, stamps
	localparam int V_LO  = 0;
	localparam int D_LO  = WAYS;
	localparam int T_LO  = 2 * WAYS;
	localparam int S_LO  = 2 * WAYS + WAYS * TAG_W;
	localparam int ROW_W = S_LO + WAYS * STAMP_W;

	localparam logic [1:0] ST_CLEAR  = 2'd0;
	localparam logic [1:0] ST_IDLE   = 2'd1;
	localparam logic [1:0] ST_LOOKUP = 2'd2;

	logic [1:0]       state_q;
	logic [SET_W-1:0] clr_q;
	logic             wb_mode_q;
	logic             wa_mode_q;
	stamp_t           use_clock_q;
	cnt_t             hits_total_q;

	logic [ROW_W-1:0] mem [NSETS];
	logic [ROW_W-1:0] row_s1;
	logic [SET_W-1:0] set_s1;
	logic [TAG_W-1:0] tag_s1;
	logic             wr_s1;

	logic             out_valid_q;
	logic             hit_q;
	way_out_t         way_q;
	logic             wb_q;
	vla_t             vla_q;
	logic             fill_q;
	logic             memw_q;
	logic             cached_q;
	cnt_t             hc_q;

	logic             accept;
	logic             complete;
	logic [SET_W-1:0] set_in;
	logic [TAG_W-1:0] tag_in;

	logic [WAYS-1:0]  vld;
	logic [WAYS-1:0]  drt;
	logic [WAYS-1:0]  match;
	logic [TAG_W-1:0] tg [WAYS];
	logic [WAYS*STAMP_W-1:0] stamps;
	logic             hit_any;
	logic             inv_any;
	logic [WAY_W-1:0] hit_way;
	logic [WAY_W-1:0] inv_way;
	logic [WAY_W-1:0] lru_way;
	logic [WAY_W-1:0] victim_way;
	logic [WAY_W-1:0] way_sel;
	logic             bypass;
	logic             evict_wb;
	logic             new_dirty;
	logic             memw;
	stamp_t           new_stamp;
	logic [ADDR_W-1:0] vla_full;
	logic [ROW_W-1:0] new_row;

	logic             mem_we;
	logic [SET_W-1:0] mem_waddr;
	logic [ROW_W-1:0] mem_wdata;

	assign accept   = in_valid && (state_q == ST_IDLE);
	assign in_stall = (state_q != ST_IDLE);
	assign complete = (state_q == ST_LOOKUP) && (!out_valid_q || !out_stall);

	assign set_in = SET_W'((address >> OFFSET_BITS) & SET_MASK);
	assign tag_in = TAG_W'(address >> (SET_BITS + OFFSET_BITS));

	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			vld[w]   = row_s1[V_LO + w];
			drt[w]   = row_s1[D_LO + w];
			tg[w]    = row_s1[T_LO + w*TAG_W +: TAG_W];
			match[w] = vld[w] && (tg[w] == tag_s1);
		end
		hit_any = |match;
		inv_any = ~&vld;
		hit_way = '0;
		inv_way = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (match[w]) begin
				hit_way = WAY_W'(w);
			end
			if (!vld[w]) begin
				inv_way = WAY_W'(w);
			end
		end
	end

	assign stamps = row_s1[S_LO +: WAYS*STAMP_W];

	sacl_lru_tree #(
		.WAYS  (WAYS),
		.WAY_W (WAY_W)
	) u_lru (
		.stamps  (stamps),
		.lru_way (lru_way)
	);

	assign bypass     = !hit_any && wr_s1 && !wa_mode_q;
	assign victim_way = inv_any ? inv_way : lru_way;
	assign way_sel    = hit_any ? hit_way : victim_way;
	assign evict_wb   = !hit_any && !bypass && !inv_any && drt[victim_way];
	assign memw       = bypass || (wr_s1 && !wb_mode_q);
	assign new_stamp  = use_clock_q + STAMP_W'(1);
	assign vla_full   = (ADDR_W'(tg[victim_way]) << SET_BITS) | (ADDR_W'(set_s1) & SET_MASK);

	always_comb begin
		new_dirty = hit_any ? drt[way_sel] : 1'b0;
		if (wr_s1 && wb_mode_q) begin
			new_dirty = 1'b1;
		end
		new_row = row_s1;
		new_row[V_LO + int'(way_sel)] = 1'b1;
		new_row[D_LO + int'(way_sel)] = new_dirty;
		new_row[T_LO + int'(way_sel)*TAG_W +: TAG_W] = tag_s1;
		new_row[S_LO + int'(way_sel)*STAMP_W +: STAMP_W] = new_stamp;
	end

	// clear sweep owns the port until done; afterwards only completing accesses write
	assign mem_we    = (state_q == ST_CLEAR) || (complete && !bypass);
	assign mem_waddr = (state_q == ST_CLEAR) ? clr_q : set_s1;
	assign mem_wdata = (state_q == ST_CLEAR) ? '0 : new_row;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (accept) begin
			row_s1 <= mem[set_in];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			set_s1 <= set_in;
			tag_s1 <= tag_in;
			wr_s1  <= (opcode == OP_WRITE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			wb_mode_q    <= 1'b1;
			wa_mode_q    <= 1'b1;
			use_clock_q  <= '0;
			hits_total_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				unique case (cfg_index)
					REG_WRITE_BACK_MODE:     wb_mode_q <= cfg_wdata[0];
					REG_WRITE_ALLOCATE_MODE: wa_mode_q <= cfg_wdata[0];
					default: ;
				endcase
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SET_W'(NSETS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_LOOKUP;
					end
				end
				ST_LOOKUP: begin
					if (complete) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_CLEAR;
			endcase
			if (complete) begin
				if (!bypass) begin
					use_clock_q <= new_stamp;
				end
				if (hit_any) begin
					hits_total_q <= hits_total_q + CNT_W'(1);
				end
			end
			if (complete) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (complete) begin
			hit_q    <= hit_any;
			way_q    <= bypass ? '0 : WAY_OUT_W'(way_sel);
			wb_q     <= evict_wb;
			vla_q    <= evict_wb ? VLA_W'(vla_full) : '0;
			fill_q   <= !hit_any && !bypass;
			memw_q   <= memw;
			cached_q <= !bypass;
			hc_q     <= hits_total_q + CNT_W'(hit_any);
		end
	end

	assign out_valid           = out_valid_q;
	assign hit                 = hit_q;
	assign way                 = way_q;
	assign victim_writeback    = wb_q;
	assign victim_line_address = vla_q;
	assign line_fill           = fill_q;
	assign memory_write        = memw_q;
	assign cached              = cached_q;
	assign hit_count           = hc_q;

endmodule

`default_nettype wire

FILE: src/sacl_checker.sv
`default_nettype none

module sacl_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic               hit,
	input sacl_pkg::way_out_t way,
	input logic               victim_writeback,
	input sacl_pkg::vla_t     victim_line_address,
	input logic               line_fill,
	input logic               memory_write,
	input logic               cached,
	input sacl_pkg::cnt_t     hit_count
);
	import sacl_pkg::*;

	// held result must not change until the transfer
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(hit_count) && $stable(way)
			&& $stable(hit) && $stable(line_fill))
		else $error("result changed while stalled");

	a_bypass: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !cached |-> !hit && !line_fill && memory_write
			&& !victim_writeback && way == '0)
		else $error("bad uncached write result");

	a_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && victim_writeback |-> line_fill && !hit && cached)
		else $error("writeback without fill");

	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && hit |-> !line_fill && cached)
		else $error("hit with fill");

	a_vla: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !victim_writeback |-> victim_line_address == '0)
		else $error("victim address without writeback");

endmodule

bind set_assoc_cache_lru_controller sacl_checker u_sacl_checker (.*);

`default_nettype wire
